>>> rtl/core/base64_stream_decoder_defines.svh
// Assertion macros shared by the decoder checks.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define B64SD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64sd check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define B64SD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64sd check failed");

`endif

>>> rtl/core/b64sd_pkg.sv
package b64sd_pkg;

    // Result queue sizing
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

    // End-of-stream status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_BAD_PAD = 2'd2;

    // Stream data widths in bits
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_DATA = 2'd1,
        KIND_PAD  = 2'd2
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t  kind;
        logic [5:0] sextet;
    } sym_class_t;

    typedef struct packed {
        logic [1:0] status;
        logic       last;
        logic       byte_valid;
        logic [7:0] out_byte;
    } result_t;

    // Map one character onto its sextet value and kind
    function automatic sym_class_t classify(input logic [7:0] c);
        sym_class_t r;
        r.kind   = KIND_SKIP;
        r.sextet = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.kind   = KIND_DATA;
            r.sextet = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.kind   = KIND_DATA;
            r.sextet = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r.kind   = KIND_DATA;
            r.sextet = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            r.kind   = KIND_DATA;
            r.sextet = 6'd62;
        end
        else if (c == 8'h2F)
        begin
            r.kind   = KIND_DATA;
            r.sextet = 6'd63;
        end
        else if (c == 8'h3D)
        begin
            r.kind = KIND_PAD;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/base64_stream_decoder.sv
// Each item is registered, decoded, and its results are written into an 8-entry queue.
// Items enter one per cycle while s_tready is high; results leave one per cycle on m_tready.
// s_tready drops while the queue might lack room for the held item's results and three more.
// Reset (rst_n low, asynchronous) empties the queue and clears all group and stream state.
module base64_stream_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [b64sd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] symbol
    input  logic                              s_tlast,   // end_of_text
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [b64sd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [9:8] status
    output logic                              m_tuser,   // byte_valid
    output logic                              m_tlast    // last
);
    import b64sd_pkg::*;

    // Input stage
    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_sym_reg;
    logic                   in_eot_reg;

    // Decoder state
    logic [5:0]             sextet_reg [3];
    logic [5:0]             sextet_next [3];
    logic [1:0]             fill_reg, fill_next;
    logic [2:0]             pad_reg, pad_next;
    logic                   any_reg, any_next;
    logic                   fin_reg, fin_next;
    logic                   err_reg, err_next;

    // Result queue
    result_t                fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    // Combinational decode
    sym_class_t             cls;
    logic                   kept;
    logic                   eot;
    logic                   close;
    logic [5:0]             sx [4];
    logic [2:0]             p;
    logic [1:0]             cnt;
    logic [1:0]             push_cnt;
    logic [1:0]             status;
    result_t                ent [3];
    logic [7:0]             bytes [3];
    logic                   pop;
    result_t                head;

    // Accept while the queue can absorb the held item's results and the new one
    assign s_tready = (count_reg + COUNT_W'(push_cnt)) <= COUNT_W'(FIFO_DEPTH - 3);
    assign in_valid_next = s_tvalid && s_tready;

    // Load the input register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sym_reg <= s_tdata[7:0];
            in_eot_reg <= s_tlast;
        end
    end

    // Decode one item into up to three results
    always_comb
    begin
        cls  = classify(in_sym_reg);
        kept = in_valid_reg && !fin_reg && (cls.kind != KIND_SKIP);
        eot  = in_valid_reg && in_eot_reg;

        sextet_next = sextet_reg;
        fill_next   = fill_reg;
        pad_next    = pad_reg;
        any_next    = any_reg | kept;
        fin_next    = fin_reg;
        err_next    = err_reg;
        close       = 1'b0;
        p           = 3'd0;
        cnt         = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            sx[i] = 6'd0;
        end

        // Add the kept symbol to the open group, closing it on the fourth
        if (kept)
        begin
            pad_next = pad_reg + {2'b00, cls.kind == KIND_PAD};
            if (fill_reg != 2'd3)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (fill_reg == 2'(i))
                    begin
                        sextet_next[i] = cls.sextet;
                    end
                end
                fill_next = fill_reg + 2'd1;
            end
            else
            begin
                close     = 1'b1;
                fill_next = 2'd0;
                sx[0]     = sextet_reg[0];
                sx[1]     = sextet_reg[1];
                sx[2]     = sextet_reg[2];
                sx[3]     = cls.sextet;
                p         = pad_next;
            end
        end

        // Fill an unfinished group with pads at end of text
        if (eot && !fin_reg && fill_next != 2'd0)
        begin
            close = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                sx[i] = (2'(i) < fill_next) ? sextet_next[i] : 6'd0;
            end
            p = pad_next + (3'd4 - {1'b0, fill_next});
        end

        // Close the group: count bytes and flag bad padding
        if (close)
        begin
            fill_next = 2'd0;
            pad_next  = 3'd0;
            if (p >= 3'd3)
            begin
                err_next = 1'b1;
                fin_next = 1'b1;
            end
            else
            begin
                cnt = 2'(3'd3 - p);
                if (p != 3'd0)
                begin
                    fin_next = 1'b1;
                end
            end
        end

        bytes[0] = {sx[0], sx[1][5:4]};
        bytes[1] = {sx[1][3:0], sx[2][5:2]};
        bytes[2] = {sx[2][1:0], sx[3]};

        if (!any_next)
        begin
            status = STATUS_EMPTY;
        end
        else if (err_next)
        begin
            status = STATUS_BAD_PAD;
        end
        else
        begin
            status = STATUS_OK;
        end

        for (int k = 0; k < 3; k++)
        begin
            ent[k].out_byte   = bytes[k];
            ent[k].byte_valid = 1'b1;
            ent[k].last       = 1'b0;
            ent[k].status     = STATUS_OK;
        end
        push_cnt = cnt;

        // Mark the final result, or send a bare end marker
        if (eot)
        begin
            if (cnt == 2'd0)
            begin
                ent[0].out_byte   = 8'd0;
                ent[0].byte_valid = 1'b0;
                ent[0].last       = 1'b1;
                ent[0].status     = status;
                push_cnt          = 2'd1;
            end
            else
            begin
                ent[cnt - 2'd1].last   = 1'b1;
                ent[cnt - 2'd1].status = status;
            end

            // Return to reset state for the next stream
            for (int i = 0; i < 3; i++)
            begin
                sextet_next[i] = 6'd0;
            end
            fill_next = 2'd0;
            pad_next  = 3'd0;
            any_next  = 1'b0;
            fin_next  = 1'b0;
            err_next  = 1'b0;
        end
    end

    // Queue pointers and fill level
    assign pop         = m_tvalid && m_tready;
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + COUNT_W'(push_cnt) - COUNT_W'(pop);

    // Write results into the queue
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < push_cnt)
            begin
                fifo_mem[wr_ptr_reg + FIFO_AW'(k)] <= ent[k];
            end
        end
    end

    // Advance control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sextet_reg[i] <= 6'd0;
            end
            fill_reg   <= 2'd0;
            pad_reg    <= 3'd0;
            any_reg    <= 1'b0;
            fin_reg    <= 1'b0;
            err_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            sextet_reg   <= sextet_next;
            fill_reg     <= fill_next;
            pad_reg      <= pad_next;
            any_reg      <= any_next;
            fin_reg      <= fin_next;
            err_reg      <= err_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    // Present the queue head
    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {6'd0, head.status, head.out_byte};
    assign m_tuser  = head.byte_valid;
    assign m_tlast  = head.last;

endmodule

>>> rtl/core/b64sd_checker.sv
`include "base64_stream_decoder_defines.svh"

module b64sd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [b64sd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] symbol
    input logic                              s_tlast,   // end_of_text
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [b64sd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [9:8] status
    input logic                              m_tuser,   // byte_valid
    input logic                              m_tlast    // last
);
    import b64sd_pkg::*;

    // Hold a stalled result
    `B64SD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Status rides only on the final result of a stream
    `B64SD_ASSERT_IMP(a_status_on_last, m_tvalid && !m_tlast, m_tdata[9:8] == STATUS_OK)

    // A result without a byte is always a zeroed end marker
    `B64SD_ASSERT_IMP(a_bare_marker, m_tvalid && !m_tuser, m_tlast && m_tdata[7:0] == 8'd0)

    // Status is one of the three defined codes
    `B64SD_ASSERT_IMP(a_status_code, m_tvalid, m_tdata[9:8] == STATUS_OK || m_tdata[9:8] == STATUS_EMPTY || m_tdata[9:8] == STATUS_BAD_PAD)

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (.*);

>>> tb/sv/base64_stream_decoder_checker.sv
`timescale 1ns / 100ps

module base64_stream_decoder_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [b64sd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] symbol
    input  logic                              s_tlast,   // end_of_text
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [b64sd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [9:8] status
    input  logic                              m_tuser,   // byte_valid
    input  logic                              m_tlast,   // last
    output int                                mismatches,
    output int                                outstanding
);
    import b64sd_pkg::*;

    // Decoder state as seen by the predictor
    logic [5:0] held_sextet [3];
    logic [1:0] held_count;
    logic [2:0] pad_count;
    logic       seen_symbol;
    logic       stream_done;
    logic       pad_error;

    // Bytes released by the item being predicted
    result_t burst [3];
    int      burst_len;

    result_t expected_bytes [$];
    int      error_total;

    function automatic sym_kind_t kind_of(input logic [7:0] c, output logic [5:0] v);
        sym_kind_t k;
        k = KIND_DATA;
        v = 6'd0;
        // upper case, lower case, digits, then the two symbols and the pad
        if (c >= 8'h41 && c <= 8'h5A)
            v = c[5:0] - 6'd1;
        else if (c >= 8'h61 && c <= 8'h7A)
            v = c[5:0] - 6'd7;
        else if (c >= 8'h30 && c <= 8'h39)
            v = c[5:0] + 6'd4;
        else if (c == 8'h2B)
            v = 6'd62;
        else if (c == 8'h2F)
            v = 6'd63;
        else if (c == 8'h3D)
            k = KIND_PAD;
        else
            k = KIND_SKIP;
        return k;
    endfunction

    function automatic void clear_stream();
        held_sextet[0] = 6'd0;
        held_sextet[1] = 6'd0;
        held_sextet[2] = 6'd0;
        held_count     = 2'd0;
        pad_count      = 3'd0;
        seen_symbol    = 1'b0;
        stream_done    = 1'b0;
        pad_error      = 1'b0;
    endfunction

    // Hold a sextet, or close the group and release its bytes
    function automatic void add_sextet(input logic [5:0] v);
        logic [7:0] b [3];
        int         keep;
        result_t    r;
        if (held_count < 2'd3)
        begin
            held_sextet[held_count] = v;
            held_count = held_count + 2'd1;
        end
        else
        begin
            b[0] = {held_sextet[0], held_sextet[1][5:4]};
            b[1] = {held_sextet[1][3:0], held_sextet[2][5:2]};
            b[2] = {held_sextet[2][1:0], v};
            held_count = 2'd0;
            if (pad_count >= 3'd3)
            begin
                pad_error   = 1'b1;
                stream_done = 1'b1;
            end
            else
            begin
                keep = 3 - int'(pad_count);
                for (int k = 0; k < keep; k++)
                begin
                    r.out_byte   = b[k];
                    r.byte_valid = 1'b1;
                    r.last       = 1'b0;
                    r.status     = STATUS_OK;
                    burst[burst_len] = r;
                    burst_len++;
                end
                if (pad_count != 3'd0)
                    stream_done = 1'b1;
            end
            pad_count = 3'd0;
        end
    endfunction

    // Work out the results of one accepted item
    function automatic void predict_item(input logic [7:0] sym, input logic eot);
        sym_kind_t  kind;
        logic [5:0] v;
        logic [1:0] st;
        burst_len = 0;
        if (!stream_done)
        begin
            kind = kind_of(sym, v);
            if (kind != KIND_SKIP)
            begin
                seen_symbol = 1'b1;
                if (kind == KIND_PAD)
                    pad_count = pad_count + 3'd1;
                add_sextet(v);
            end
        end
        if (eot)
        begin
            // fill an open group with pads
            if (!stream_done)
                while (held_count != 2'd0)
                begin
                    pad_count = pad_count + 3'd1;
                    add_sextet(6'd0);
                end
            if (!seen_symbol)
                st = STATUS_EMPTY;
            else if (pad_error)
                st = STATUS_BAD_PAD;
            else
                st = STATUS_OK;
            if (burst_len == 0)
            begin
                burst[0]  = '0;
                burst_len = 1;
            end
            burst[burst_len-1].last   = 1'b1;
            burst[burst_len-1].status = st;
            clear_stream();
        end
        for (int k = 0; k < burst_len; k++)
            expected_bytes.push_back(burst[k]);
    endfunction

    function automatic void note_failure(input string msg);
        error_total++;
        if (error_total <= 10)
            $display("%0t ns mismatch: %s", $realtime, msg);
    endfunction

    // Compare one delivered item against the oldest expectation
    function automatic void check_result();
        result_t want;
        if (expected_bytes.size() == 0)
            note_failure($sformatf("unexpected item: byte %02h valid %0b last %0b status %0d",
                                   m_tdata[7:0], m_tuser, m_tlast, m_tdata[9:8]));
        else
        begin
            want = expected_bytes.pop_front();
            if (m_tdata[7:0] !== want.out_byte || m_tuser !== want.byte_valid ||
                m_tlast !== want.last || m_tdata[9:8] !== want.status)
                note_failure($sformatf({"expected byte %02h valid %0b last %0b status %0d, ",
                                        "got byte %02h valid %0b last %0b status %0d"},
                                       want.out_byte, want.byte_valid, want.last, want.status,
                                       m_tdata[7:0], m_tuser, m_tlast, m_tdata[9:8]));
        end
    endfunction

    // Predict on input handshakes, compare on output handshakes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_stream();
            expected_bytes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_item(s_tdata[7:0], s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            outstanding <= expected_bytes.size();
            mismatches  <= error_total;
        end
    end

endmodule

>>> tb/sv/base64_stream_decoder_tb.sv
`timescale 1ns / 100ps

module base64_stream_decoder_tb;
    import b64sd_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_ITEMS = 75;
    localparam logic [7:0] PAD_CHAR     = 8'h3D;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;    // [7:0] symbol
    logic                   s_tlast  = 1'b0;  // end_of_text
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [7:0] out_byte, [9:8] status
    logic                   m_tuser;          // byte_valid
    logic                   m_tlast;          // last

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int send_idle_pct = 23;
    int recv_stall_pct = 76;

    logic [7:0] chars [$];

    base64_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    base64_stream_decoder_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Stall the output side at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("base64_stream_decoder regression: fail");
            $finish;
        end
    end

    function automatic bit is_kept(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F || c == PAD_CHAR;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + v;
        else if (v < 6'd52)
            return 8'h61 + (v - 6'd26);
        else if (v < 6'd62)
            return 8'h30 + (v - 6'd52);
        else if (v == 6'd62)
            return 8'h2B;
        return 8'h2F;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (is_kept(c))
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // Add a character, sometimes after a skipped one
    function automatic void add_char(input logic [7:0] c);
        if ($urandom_range(7) == 0)
            chars.push_back(junk_char());
        chars.push_back(c);
    endfunction

    // Present one item and hold it until taken
    task automatic send_item(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], i == txt.len() - 1);
    endtask

    task automatic send_chars();
        for (int i = 0; i < chars.size(); i++)
            send_item(chars[i], i == chars.size() - 1);
    endtask

    // Encode a random byte string, padded or not
    function automatic void build_encoded();
        int          nbytes;
        int          rem;
        bit          padded;
        logic [23:0] word;
        nbytes = $urandom_range(9);
        padded = ($urandom_range(3) != 0);
        for (int i = 0; i < nbytes; i += 3)
        begin
            rem  = (nbytes - i > 3) ? 3 : nbytes - i;
            word = 24'($urandom());
            for (int k = 0; k < 4; k++)
                if (k <= rem)
                    add_char(sextet_char(word[23-6*k -: 6]));
                else if (padded)
                    add_char(PAD_CHAR);
        end
        // trailing characters; they land after the end of decoding only when a pad has closed the stream
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                add_char(sextet_char(6'($urandom_range(63))));
        if (chars.size() == 0)
            chars.push_back(junk_char());
    endfunction

    // Mostly pads and symbols in no particular order
    function automatic void build_broken();
        repeat ($urandom_range(1, 10))
            case ($urandom_range(3))
                0, 2:    chars.push_back(PAD_CHAR);
                1:       chars.push_back(sextet_char(6'($urandom_range(63))));
                default: chars.push_back(8'($urandom_range(255)));
            endcase
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 8))
            chars.push_back(8'($urandom_range(255)));
    endfunction

    initial
    begin
        int sent_items;
        int pick;
        sent_items = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty streams, padding cases, short groups, full group
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_text("QQ==AB");
        send_text("Q===");
        send_text("Q");
        send_text("QUI");
        send_text("+/9z");
        send_text("AB=C");

        // Random streams over three idling phases
        while (sent_items < RANDOM_ITEMS)
        begin
            if (sent_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct  = 23;
                recv_stall_pct = 76;
            end
            else if (sent_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct  = 76;
                recv_stall_pct = 23;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            chars.delete();
            pick = $urandom_range(9);
            if (pick < 6)
                build_encoded();
            else if (pick < 8)
                build_broken();
            else
                build_noise();
            sent_items += chars.size();
            send_chars();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain the remaining results
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("base64_stream_decoder regression: pass");
        else
            $display("base64_stream_decoder regression: fail");
        $finish;
    end

endmodule
